FILE: sv/svme_pkg.sv
// Shared constants, codes and beat types of the vertex message engine.
package svme_pkg;

	localparam int MAX_NODES  = 256;
	localparam int MAX_DEGREE = 16;

	localparam int NODE_AW = $clog2(MAX_NODES);
	localparam int DEG_AW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int EC_W    = $clog2(MAX_DEGREE + 1);

	localparam int PEER_W   = 8;
	localparam int WEIGHT_W = 31;
	localparam int EDGE_W   = PEER_W + WEIGHT_W;
	localparam int PAR_W    = 9;
	localparam int SUCC_W   = 9;

	localparam logic [31:0] DIST_INF = 32'h4000_0000;
	localparam logic [31:0] SAT_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] NONE_32  = 32'hFFFF_FFFF;
	localparam logic [PAR_W-1:0] NO_PARENT = '1;

	// input item kinds
	localparam logic [2:0] K_EDGE    = 3'd0;
	localparam logic [2:0] K_START   = 3'd1;
	localparam logic [2:0] K_UPDATE  = 3'd2;
	localparam logic [2:0] K_TERM    = 3'd3;
	localparam logic [2:0] K_COLLECT = 3'd4;
	localparam logic [2:0] K_READ    = 3'd5;

	// outgoing message kinds
	localparam logic [2:0] M_STATUS  = 3'd0;
	localparam logic [2:0] M_UPDATE  = 3'd1;
	localparam logic [2:0] M_TOKEN   = 3'd2;
	localparam logic [2:0] M_COLLECT = 3'd3;
	localparam logic [2:0] M_RDATA   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] R_NODE_ID    = 2'd0;
	localparam logic [1:0] R_SOURCE     = 2'd1;
	localparam logic [1:0] R_NODE_COUNT = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  dest;
		logic [31:0] payload;
	} msg_t;

	typedef struct packed {
		msg_t msg;
		logic last;
		logic finished;
	} res_t;

	typedef struct packed {
		logic              busy;
		logic [SUCC_W-1:0] value;
	} succ_t;

endpackage

FILE: sv/svme_ram.sv
// Generic single-port-write, registered-read RAM.
module svme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/svme_succ.sv
// Ring successor unit: (node_id + 1) mod node_count by shift-and-subtract.
module svme_succ (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [7:0]          node_id,
	input  logic [8:0]          node_count,
	output svme_pkg::succ_t     succ
);

	logic       busy_q;
	logic       load_q;
	logic [3:0] cnt_q;
	logic [8:0] rem_q;
	logic [8:0] div_q;
	logic [16:0] shifted;
	logic        take;

	assign shifted = {8'd0, div_q} << cnt_q;
	assign take    = {8'd0, rem_q} >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			load_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= 9'd1;
		end else if (start) begin
			// registers settle on this edge: load on the next one
			busy_q <= 1'b1;
			load_q <= 1'b1;
		end else if (load_q) begin
			load_q <= 1'b0;
			rem_q  <= {1'b0, node_id} + 9'd1;
			div_q  <= (node_count == 9'd0) ? 9'd1 : node_count;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - shifted[8:0];
			end
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	assign succ.busy  = busy_q;
	assign succ.value = rem_q;

endmodule

FILE: sv/svme_obuf.sv
// Output register: holds one result beat and parts the engine from the sink.
module svme_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  svme_pkg::res_t      push_res,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          msg_kind,
	output logic [7:0]          dest,
	output logic signed [31:0]  payload,
	output logic                last,
	output logic                finished
);

	logic           valid_q;
	svme_pkg::res_t res_q;

	assign push_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push_valid) begin
			res_q <= push_res;
		end
	end

	assign out_valid = valid_q;
	assign msg_kind  = res_q.msg.kind;
	assign dest      = res_q.msg.dest;
	assign payload   = $signed(res_q.msg.payload);
	assign last      = res_q.last;
	assign finished  = res_q.finished;

endmodule

FILE: sv/sssp_vertex_message_engine_unit.sv
// Top level: one shortest-path vertex with edge table, parent table and token ring control.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  in      | in_valid / in_ready     | kind, peer, value
//  out     | out_valid / out_ready   | msg_kind, dest, payload, last, finished
//
// An item is decoded and then sends its result beats: n beats for a relax
// over n stored edges (plus one more for a ring token), two for a token forward with a
// parent report, one for every other item.
// Relax beats stream from the edge RAM one entry a cycle, while the sink accepts them.
// After any configuration write the successor unit recomputes with in_ready low.
// Reset clears all control state; the edge and parent tables need no clearing pass.
// A stalled sink holds the current beat and the engine with it; cfg_ready is always high.
module sssp_vertex_message_engine_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [7:0]         peer,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         msg_kind,
	output logic [7:0]         dest,
	output logic signed [31:0] payload,
	output logic               last,
	output logic               finished
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELAX,
		ST_TOKEN,
		ST_ONE,
		ST_TWO,
		ST_READ
	} state_t;

	state_t state_q;

	logic [7:0]  node_id_q;
	logic [7:0]  source_q;
	logic [8:0]  count_q;
	logic [31:0] dist_q;
	logic [svme_pkg::PAR_W-1:0] parent_q;
	logic        color_q;
	logic [1:0]  pass_q;
	logic        started_q;
	logic        done_q;
	logic [8:0]  collected_q;
	logic [svme_pkg::EC_W-1:0] edge_cnt_q;
	logic [svme_pkg::EC_W-1:0] idx_q;
	logic        tok_after_q;
	svme_pkg::msg_t res_a_q;
	svme_pkg::msg_t res_b_q;
	logic        has_b_q;
	logic [7:0]  rd_peer_q;
	logic        peer_ok_q;

	svme_pkg::succ_t succ;
	svme_pkg::res_t  push_res;
	logic            push_valid;
	logic            push_ready;
	logic            fire;
	logic            accept;
	logic            cfg_fire;

	logic [svme_pkg::EC_W-1:0]   idx_nxt;
	logic [svme_pkg::DEG_AW-1:0] edge_raddr;
	logic [svme_pkg::EDGE_W-1:0] edge_wdata;
	logic [svme_pkg::EDGE_W-1:0] edge_rdata;
	logic                        edge_we;
	logic [7:0]                  e_nb;
	logic [svme_pkg::WEIGHT_W-1:0] e_w;
	logic [32:0]                 sum;
	logic [31:0]                 relax_val;

	logic [svme_pkg::NODE_AW-1:0] ptab_addr;
	logic [svme_pkg::PAR_W-1:0]   ptab_rdata;
	logic                         ptab_we;
	logic                         ptab_re;
	logic                         peer_ok;

	logic        is_src;
	logic        improve;
	logic        tok_upd;
	logic        has_edges;
	logic        term_token;
	logic        term_restart;
	logic        fwd_ok;
	logic [8:0]  coll_next;
	logic        coll_done;
	logic [31:0] parent_ext;
	svme_pkg::msg_t status_msg;
	svme_pkg::msg_t succ_tok_msg;
	svme_pkg::msg_t fwd_tok_msg;
	svme_pkg::msg_t collect_msg;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == ST_IDLE) && !succ.busy;
	assign accept    = in_valid && in_ready;
	assign fire      = push_valid && push_ready;

	svme_succ u_succ (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cfg_fire),
		.node_id    (node_id_q),
		.node_count (count_q),
		.succ       (succ)
	);

	// edge table: neighbor in the top bits, clamped weight below
	assign edge_we    = accept && (kind == svme_pkg::K_EDGE)
		&& (edge_cnt_q < svme_pkg::EC_W'(svme_pkg::MAX_DEGREE));
	assign edge_wdata = {peer, value[31] ? {svme_pkg::WEIGHT_W{1'b0}} : value[30:0]};
	assign idx_nxt    = idx_q + svme_pkg::EC_W'(1);
	assign edge_raddr = (state_q != ST_RELAX) ? '0
		: (fire ? idx_nxt[svme_pkg::DEG_AW-1:0] : idx_q[svme_pkg::DEG_AW-1:0]);

	svme_ram #(
		.WIDTH (svme_pkg::EDGE_W),
		.DEPTH (svme_pkg::MAX_DEGREE)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_cnt_q[svme_pkg::DEG_AW-1:0]),
		.wdata (edge_wdata),
		.re    (1'b1),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	assign e_nb = edge_rdata[svme_pkg::EDGE_W-1 -: 8];
	assign e_w  = edge_rdata[svme_pkg::WEIGHT_W-1:0];
	assign sum  = {dist_q[31], dist_q} + {2'b00, e_w};
	// saturate on positive overflow only
	assign relax_val = (!sum[32] && sum[31]) ? svme_pkg::SAT_MAX : sum[31:0];

	assign peer_ok   = {24'd0, peer} < 32'(svme_pkg::MAX_NODES);
	assign ptab_addr = svme_pkg::NODE_AW'(peer);
	assign ptab_we   = accept && (kind == svme_pkg::K_COLLECT) && !done_q && peer_ok;
	assign ptab_re   = accept && (kind == svme_pkg::K_READ);

	svme_ram #(
		.WIDTH (svme_pkg::PAR_W),
		.DEPTH (svme_pkg::MAX_NODES)
	) u_parent_ram (
		.clk   (clk),
		.we    (ptab_we),
		.waddr (ptab_addr),
		.wdata (value[svme_pkg::PAR_W-1:0]),
		.re    (ptab_re),
		.raddr (ptab_addr),
		.rdata (ptab_rdata)
	);

	// decode terms, all from state before the item
	assign is_src       = node_id_q == source_q;
	assign improve      = $signed(value) < $signed(dist_q);
	assign tok_upd      = (node_id_q == 8'd0) && !started_q;
	assign has_edges    = edge_cnt_q != '0;
	assign term_token   = color_q & value[0];
	assign term_restart = (value == 32'sd0) && (pass_q == 2'd0)
		&& (node_id_q == 8'd0) && color_q;
	assign fwd_ok       = ({1'b0, node_id_q} + 9'd1) < count_q;
	assign coll_next    = collected_q + 9'd1;
	assign coll_done    = ({1'b0, coll_next} + 10'd1) == {1'b0, count_q};
	assign parent_ext   = {{(32 - svme_pkg::PAR_W){parent_q[svme_pkg::PAR_W-1]}}, parent_q};

	assign status_msg   = '{kind: svme_pkg::M_STATUS, dest: 8'd0, payload: 32'd0};
	assign succ_tok_msg = '{kind: svme_pkg::M_TOKEN, dest: succ.value[7:0],
		payload: {31'd0, term_token}};
	assign fwd_tok_msg  = '{kind: svme_pkg::M_TOKEN, dest: node_id_q + 8'd1,
		payload: {31'd0, term_token}};
	assign collect_msg  = '{kind: svme_pkg::M_COLLECT, dest: source_q, payload: parent_ext};

	always_comb begin
		push_valid           = 1'b0;
		push_res.msg         = status_msg;
		push_res.last        = 1'b1;
		push_res.finished    = done_q;
		case (state_q)
			ST_RELAX: begin
				push_valid       = 1'b1;
				push_res.msg     = '{kind: svme_pkg::M_UPDATE, dest: e_nb, payload: relax_val};
				push_res.last    = (idx_nxt == edge_cnt_q) && !tok_after_q;
			end
			ST_TOKEN: begin
				push_valid       = 1'b1;
				push_res.msg     = '{kind: svme_pkg::M_TOKEN, dest: succ.value[7:0],
					payload: {31'd0, color_q}};
			end
			ST_ONE: begin
				push_valid       = 1'b1;
				push_res.msg     = res_a_q;
				push_res.last    = !has_b_q;
			end
			ST_TWO: begin
				push_valid       = 1'b1;
				push_res.msg     = res_b_q;
			end
			ST_READ: begin
				push_valid       = 1'b1;
				push_res.msg     = '{kind: svme_pkg::M_RDATA, dest: rd_peer_q,
					payload: peer_ok_q
						? {{(32 - svme_pkg::PAR_W){ptab_rdata[svme_pkg::PAR_W-1]}}, ptab_rdata}
						: svme_pkg::NONE_32};
			end
			default: begin
				push_valid       = 1'b0;
			end
		endcase
	end

	svme_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_res   (push_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.msg_kind   (msg_kind),
		.dest       (dest),
		.payload    (payload),
		.last       (last),
		.finished   (finished)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			node_id_q   <= 8'd0;
			source_q    <= 8'd0;
			count_q     <= 9'd1;
			dist_q      <= svme_pkg::DIST_INF;
			parent_q    <= svme_pkg::NO_PARENT;
			color_q     <= 1'b1;
			pass_q      <= 2'd0;
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			collected_q <= 9'd0;
			edge_cnt_q  <= '0;
			idx_q       <= '0;
			tok_after_q <= 1'b0;
			has_b_q     <= 1'b0;
			peer_ok_q   <= 1'b0;
			rd_peer_q   <= 8'd0;
			res_a_q     <= '0;
			res_b_q     <= '0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					svme_pkg::R_NODE_ID:    node_id_q <= cfg_data[7:0];
					svme_pkg::R_SOURCE:     source_q  <= cfg_data[7:0];
					svme_pkg::R_NODE_COUNT: count_q   <= cfg_data[8:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_a_q <= status_msg;
						has_b_q <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_ONE;
						case (kind)
							svme_pkg::K_EDGE: begin
								if (edge_we) begin
									edge_cnt_q <= edge_cnt_q + svme_pkg::EC_W'(1);
								end
							end
							svme_pkg::K_START: begin
								parent_q    <= svme_pkg::NO_PARENT;
								color_q     <= 1'b1;
								pass_q      <= 2'd0;
								started_q   <= 1'b0;
								done_q      <= 1'b0;
								collected_q <= 9'd0;
								tok_after_q <= 1'b0;
								if (is_src) begin
									dist_q <= 32'd0;
									if (has_edges) begin
										state_q <= ST_RELAX;
									end
								end else begin
									dist_q <= svme_pkg::DIST_INF;
								end
							end
							svme_pkg::K_READ: begin
								rd_peer_q <= peer;
								peer_ok_q <= peer_ok;
								state_q   <= ST_READ;
							end
							svme_pkg::K_UPDATE: begin
								if (!done_q) begin
									if (improve) begin
										dist_q   <= value;
										parent_q <= {1'b0, peer};
									end
									if (tok_upd) begin
										pass_q    <= 2'd1;
										started_q <= 1'b1;
									end
									tok_after_q <= tok_upd;
									if (improve && has_edges) begin
										state_q <= ST_RELAX;
									end else if (tok_upd) begin
										state_q <= ST_TOKEN;
									end
								end
							end
							svme_pkg::K_TERM: begin
								if (!done_q) begin
									if (term_restart) begin
										// first token from the ring head
										res_a_q <= '{kind: svme_pkg::M_TOKEN,
											dest: succ.value[7:0], payload: 32'd1};
										pass_q  <= 2'd1;
									end else begin
										color_q <= 1'b1;
										if (pass_q == 2'd2) begin
											if (fwd_ok) begin
												res_a_q <= fwd_tok_msg;
												if (!is_src) begin
													res_b_q <= collect_msg;
													has_b_q <= 1'b1;
												end
											end else if (!is_src) begin
												res_a_q <= collect_msg;
											end
											if (!is_src) begin
												done_q <= 1'b1;
											end
										end else begin
											res_a_q <= succ_tok_msg;
											pass_q  <= term_token ? pass_q + 2'd1 : 2'd0;
										end
									end
								end
							end
							svme_pkg::K_COLLECT: begin
								if (!done_q) begin
									collected_q <= coll_next;
									if (coll_done) begin
										done_q <= 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_RELAX: begin
					if (fire) begin
						// a lower-numbered neighbor dirties the token color
						if (e_nb < node_id_q) begin
							color_q <= 1'b0;
						end
						idx_q <= idx_nxt;
						if (idx_nxt == edge_cnt_q) begin
							state_q <= tok_after_q ? ST_TOKEN : ST_IDLE;
						end
					end
				end
				ST_ONE: begin
					if (fire) begin
						state_q <= has_b_q ? ST_TWO : ST_IDLE;
					end
				end
				ST_TOKEN, ST_TWO, ST_READ: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_relax_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX |-> (edge_cnt_q != '0) && (idx_q < edge_cnt_q))
		else $error("relax index outside stored edges");

	a_item_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item produced no result");

	a_two_after_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TWO |-> $past(state_q) == ST_ONE || $past(state_q) == ST_TWO)
		else $error("second result without first");

	a_done_on_decode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(accept))
		else $error("done set outside item decode");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		succ.busy |-> !accept)
		else $error("item taken while successor is stale");

endmodule
